// File: sv/mvfb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mvfb_pkg
// Shared constants, register indexes and types for the motion vector blur.
// ============================================================================
package mvfb_pkg;

   localparam int PIXEL_W   = 32;
   localparam int SHIFT_W   = 8;
   localparam int DIM_CFG_W = 9;
   localparam int CSR_IDX_W = 2;
   localparam int SEL_W     = 2;
   localparam int Q_DEPTH   = 4;

   // per-byte quarter mask after the right shift by two
   localparam logic [PIXEL_W-1:0] QUARTER_MASK = 32'h3f3f3f3f;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   // action codes of an input word
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_BLUR = 1'b1;

   // sample selects, issued in this order
   localparam logic [SEL_W-1:0] SEL_LEFT   = 2'd0;
   localparam logic [SEL_W-1:0] SEL_RIGHT  = 2'd1;
   localparam logic [SEL_W-1:0] SEL_ABOVE  = 2'd2;
   localparam logic [SEL_W-1:0] SEL_CENTER = 2'd3;

   typedef struct packed {
      logic is_load;
      logic last;
   } mvfb_tag_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] blurred_pixel;
      logic               last_of_frame;
   } mvfb_rsp_type;

   function automatic logic signed [2:0] sample_dx(input logic [SEL_W-1:0] sel);
      logic signed [2:0] d;
      case (sel)
         SEL_LEFT:  d = -3'sd2;
         SEL_RIGHT: d = 3'sd2;
         default:   d = 3'sd0;
      endcase
      return d;
   endfunction

   function automatic logic signed [2:0] sample_dy(input logic [SEL_W-1:0] sel);
      logic signed [2:0] d;
      case (sel)
         SEL_LEFT:  d = 3'sd1;
         SEL_RIGHT: d = 3'sd1;
         SEL_ABOVE: d = -3'sd2;
         default:   d = 3'sd0;
      endcase
      return d;
   endfunction

endpackage

// File: sv/mvfb_front.sv
`timescale 1ns / 1ps
// ============================================================================
// mvfb_front
// Accepts words, tracks load and blur positions, and forms queue entries.
// ============================================================================
module mvfb_front #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   localparam int CW    = $clog2(MAX_WIDTH),
   localparam int RW    = $clog2(MAX_HEIGHT),
   localparam int WW    = $clog2(MAX_WIDTH + 1),
   localparam int HW    = $clog2(MAX_HEIGHT + 1),
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
   localparam int AW    = $clog2(DEPTH),
   localparam int TW    = $clog2(DEPTH + 1),
   localparam int XW    = ((CW > mvfb_pkg::SHIFT_W) ? CW : mvfb_pkg::SHIFT_W) + 2,
   localparam int YW    = ((RW > mvfb_pkg::SHIFT_W) ? RW : mvfb_pkg::SHIFT_W) + 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_action,
   input  logic [mvfb_pkg::PIXEL_W-1:0]         req_source_pixel,
   input  logic signed [mvfb_pkg::SHIFT_W-1:0]  req_shift_x,
   input  logic signed [mvfb_pkg::SHIFT_W-1:0]  req_shift_y,
   input  logic [WW-1:0]                        w_eff,
   input  logic [HW-1:0]                        h_eff,
   input  logic [TW-1:0]                        total,
   input  logic                                 cfg_settle,
   input  logic                                 q_full,
   output logic                                 push,
   output mvfb_pkg::mvfb_tag_type               push_tag,
   output logic [mvfb_pkg::PIXEL_W-1:0]         push_data,
   output logic [AW-1:0]                        push_addr,
   output logic signed [XW-1:0]                 push_x,
   output logic signed [YW-1:0]                 push_y
);
   import mvfb_pkg::*;

   logic [AW-1:0] load_pos_ff, load_pos_in, load_cur;
   logic [CW-1:0] col_ff, col_in, col_cur;
   logic [RW-1:0] row_ff, row_in, row_cur;
   logic          restart, at_last_col, at_last_row, accept;

   assign busy   = q_full || cfg_settle;
   assign accept = start && !busy;
   assign push   = accept;

   // restart the load walk when the frame shrank under it, wrap after the end
   always_comb begin
      load_cur = (32'(load_pos_ff) >= 32'(total)) ? '0 : load_pos_ff;
      if ((32'(load_cur) + 32'd1) >= 32'(total)) begin
         load_pos_in = '0;
      end else begin
         load_pos_in = load_cur + 1'b1;
      end
   end

   // blur walk: restart at the origin when outside the frame in use
   always_comb begin
      restart     = (32'(col_ff) >= 32'(w_eff)) || (32'(row_ff) >= 32'(h_eff));
      col_cur     = restart ? '0 : col_ff;
      row_cur     = restart ? '0 : row_ff;
      at_last_col = (32'(col_cur) == (32'(w_eff) - 32'd1));
      at_last_row = (32'(row_cur) == (32'(h_eff) - 32'd1));
      if (at_last_col) begin
         col_in = '0;
         row_in = at_last_row ? '0 : row_cur + 1'b1;
      end else begin
         col_in = col_cur + 1'b1;
         row_in = row_cur;
      end
   end

   assign push_tag.is_load = (req_action == ACT_LOAD);
   assign push_tag.last    = at_last_col && at_last_row;
   assign push_data        = req_source_pixel;
   assign push_addr        = load_cur;
   assign push_x = $signed({{(XW - CW){1'b0}}, col_cur})
                 + $signed({{(XW - SHIFT_W){req_shift_x[SHIFT_W-1]}}, req_shift_x});
   assign push_y = $signed({{(YW - RW){1'b0}}, row_cur})
                 + $signed({{(YW - SHIFT_W){req_shift_y[SHIFT_W-1]}}, req_shift_y});

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else if (accept) begin
         if (req_action == ACT_LOAD) begin
            load_pos_ff <= load_pos_in;
         end else begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

endmodule

// File: sv/mvfb_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// mvfb_queue
// Short show-ahead queue between the front and the back.
// ============================================================================
module mvfb_queue #(
   parameter int WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mvfb_pkg::mvfb_tag_type push_tag,
   input  logic [WIDTH-1:0]       push_word,
   input  logic                   pop,
   output mvfb_pkg::mvfb_tag_type head_tag,
   output logic [WIDTH-1:0]       head_word,
   output logic                   empty,
   output logic                   full
);
   import mvfb_pkg::*;

   localparam int QAW = $clog2(Q_DEPTH);

   mvfb_tag_type     tag_ff  [Q_DEPTH];
   logic [WIDTH-1:0] word_ff [Q_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QAW:0]     count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == (QAW + 1)'(Q_DEPTH));
   assign head_tag  = tag_ff[rd_ptr_ff];
   assign head_word = word_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         tag_ff[wr_ptr_ff]  <= push_tag;
         word_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QAW + 1)'(Q_DEPTH))
      else $error("queue count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("push into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from an empty queue");

endmodule

// File: sv/mvfb_back.sv
`timescale 1ns / 1ps
// ============================================================================
// mvfb_back
// Sample sequencer, address pipeline, frame store and quarter-sum accumulator.
// ============================================================================
module mvfb_back #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   localparam int CW    = $clog2(MAX_WIDTH),
   localparam int RW    = $clog2(MAX_HEIGHT),
   localparam int WW    = $clog2(MAX_WIDTH + 1),
   localparam int HW    = $clog2(MAX_HEIGHT + 1),
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
   localparam int AW    = $clog2(DEPTH),
   localparam int XW    = ((CW > mvfb_pkg::SHIFT_W) ? CW : mvfb_pkg::SHIFT_W) + 2,
   localparam int YW    = ((RW > mvfb_pkg::SHIFT_W) ? RW : mvfb_pkg::SHIFT_W) + 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [WW-1:0]                w_eff,
   input  logic [HW-1:0]                h_eff,
   input  logic                         q_empty,
   input  mvfb_pkg::mvfb_tag_type       q_tag,
   input  logic [mvfb_pkg::PIXEL_W-1:0] q_data,
   input  logic [AW-1:0]                q_addr,
   input  logic signed [XW-1:0]         q_x,
   input  logic signed [YW-1:0]         q_y,
   output logic                         pop,
   output logic                         rsp_valid,
   output mvfb_pkg::mvfb_rsp_type       rsp
);
   import mvfb_pkg::*;

   logic [PIXEL_W-1:0] store [DEPTH];

   logic [SEL_W-1:0]   sel_ff;
   logic               issue;

   logic signed [2:0]  dx;
   logic signed [2:0]  dy;
   logic signed [XW:0] sx;
   logic signed [YW:0] sy;
   logic signed [XW:0] x_hi;
   logic signed [YW:0] y_hi;
   logic [CW-1:0]      cx;
   logic [RW-1:0]      cy;

   logic               s1_valid_ff, s1_first_ff, s1_final_ff;
   mvfb_tag_type       s1_tag_ff;
   logic [CW-1:0]      s1_cx_ff;
   logic [RW-1:0]      s1_cy_ff;
   logic [AW-1:0]      s1_addr_ff;
   logic [PIXEL_W-1:0] s1_data_ff;

   logic [RW+WW-1:0]   row_base;
   logic [RW+WW:0]     sample_addr;

   logic               s2_valid_ff, s2_first_ff, s2_final_ff;
   mvfb_tag_type       s2_tag_ff;
   logic [AW-1:0]      s2_addr_ff;
   logic [PIXEL_W-1:0] s2_data_ff;

   logic               s3_valid_ff, s3_first_ff, s3_final_ff, s3_last_ff;
   logic [PIXEL_W-1:0] rd_data_ff;

   logic [PIXEL_W-1:0] quarter, acc_in, acc_ff;
   logic               rsp_valid_ff;
   mvfb_rsp_type       rsp_ff;

   // one store access a cycle while the queue holds a word: one access for a load, four for a blur
   assign issue = !q_empty;
   assign pop   = issue && (q_tag.is_load || (sel_ff == SEL_CENTER));

   // clamp each coordinate of the sample to the frame in use
   always_comb begin
      dx   = sample_dx(sel_ff);
      dy   = sample_dy(sel_ff);
      sx   = $signed({q_x[XW-1], q_x}) + $signed({{(XW - 2){dx[2]}}, dx});
      sy   = $signed({q_y[YW-1], q_y}) + $signed({{(YW - 2){dy[2]}}, dy});
      x_hi = $signed({{(XW + 1 - WW){1'b0}}, w_eff}) - (XW + 1)'(1);
      y_hi = $signed({{(YW + 1 - HW){1'b0}}, h_eff}) - (YW + 1)'(1);
      if (sx[XW]) begin
         cx = '0;
      end else if (sx > x_hi) begin
         cx = x_hi[CW-1:0];
      end else begin
         cx = sx[CW-1:0];
      end
      if (sy[YW]) begin
         cy = '0;
      end else if (sy > y_hi) begin
         cy = y_hi[RW-1:0];
      end else begin
         cy = sy[RW-1:0];
      end
   end

   always_comb begin
      row_base    = s1_cy_ff * w_eff;
      sample_addr = {1'b0, row_base} + (RW + WW + 1)'(s1_cx_ff);
   end

   always_comb begin
      quarter = (rd_data_ff >> 2) & QUARTER_MASK;
      acc_in  = s3_first_ff ? quarter : acc_ff + quarter;
   end

   // control of the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= SEL_LEFT;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (issue && !q_tag.is_load) begin
            sel_ff <= pop ? SEL_LEFT : sel_ff + 1'b1;
         end
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff && !s2_tag_ff.is_load;
         rsp_valid_ff <= s3_valid_ff && s3_final_ff;
      end
   end

   // payload of the stages
   always_ff @(posedge clock) begin
      s1_tag_ff   <= q_tag;
      s1_first_ff <= (sel_ff == SEL_LEFT);
      s1_final_ff <= pop;
      s1_cx_ff    <= cx;
      s1_cy_ff    <= cy;
      s1_addr_ff  <= q_addr;
      s1_data_ff  <= q_data;

      s2_tag_ff   <= s1_tag_ff;
      s2_first_ff <= s1_first_ff;
      s2_final_ff <= s1_final_ff;
      s2_addr_ff  <= s1_tag_ff.is_load ? s1_addr_ff : sample_addr[AW-1:0];
      s2_data_ff  <= s1_data_ff;

      s3_first_ff <= s2_first_ff;
      s3_final_ff <= s2_final_ff;
      s3_last_ff  <= s2_tag_ff.last;

      if (s3_valid_ff) begin
         acc_ff <= acc_in;
      end
      rsp_ff.blurred_pixel <= acc_in;
      rsp_ff.last_of_frame <= s3_last_ff;
   end

   // frame store, single port
   always_ff @(posedge clock) begin
      if (s2_valid_ff && s2_tag_ff.is_load) begin
         store[s2_addr_ff] <= s2_data_ff;
      end
      rd_data_ff <= store[s2_addr_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_samples_contiguous: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_tag_ff.is_load && !s1_first_ff)
      |-> $past(s1_valid_ff && !s1_tag_ff.is_load && !s1_final_ff))
      else $error("blur samples not issued back to back");

   a_acc_follows: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !s3_first_ff) |-> ($past(s3_valid_ff) && !$past(s3_final_ff)))
      else $error("accumulation without a preceding sample");

endmodule

// File: sv/motion_vector_frame_blur.sv
`timescale 1ns / 1ps
// ============================================================================
// motion_vector_frame_blur
// Frame store with motion-displaced four-tap quarter-sum blur.
// ============================================================================
// Path: a blur word's result passes the queue, the sample issue, stages s1,
//   s2 and s3 and the response register; a load word gives no result.
// Throughput: a load takes one access and a blur four accesses of the single
//   frame store port, one store access per cycle; the front takes a word per
//   cycle while the 4-entry queue has room and no register write settles.
// Reset (synchronous): clears the walks and the queue, sets both dimension
//   registers to 256; busy is high for one cycle after reset and after each
//   register write. The frame store is not cleared. Results cannot be stalled.
module motion_vector_frame_blur #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_action,
   input  logic [mvfb_pkg::PIXEL_W-1:0]          req_source_pixel,
   input  logic signed [mvfb_pkg::SHIFT_W-1:0]   req_shift_x,
   input  logic signed [mvfb_pkg::SHIFT_W-1:0]   req_shift_y,
   output logic                                  rsp_valid,
   output logic [mvfb_pkg::PIXEL_W-1:0]          rsp_blurred_pixel,
   output logic                                  rsp_last_of_frame,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mvfb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mvfb_pkg::DIM_CFG_W-1:0]        csr_wdata
);
   import mvfb_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int TW    = $clog2(DEPTH + 1);
   localparam int XW    = ((CW > SHIFT_W) ? CW : SHIFT_W) + 2;
   localparam int YW    = ((RW > SHIFT_W) ? RW : SHIFT_W) + 2;
   localparam int QW    = PIXEL_W + AW + XW + YW;

   // dimension registers as written
   logic [DIM_CFG_W-1:0] width_ff, height_ff;
   logic                 settle_ff;
   logic                 csr_write;

   // dimensions in use and the frame area; only the area total is registered
   logic [WW-1:0]        w_eff;
   logic [HW-1:0]        h_eff;
   logic [WW+HW-1:0]     area;
   logic [TW-1:0]        total_ff;

   // front to queue
   logic                 push;
   mvfb_tag_type         push_tag;
   logic [PIXEL_W-1:0]   push_data;
   logic [AW-1:0]        push_addr;
   logic signed [XW-1:0] push_x;
   logic signed [YW-1:0] push_y;
   logic [QW-1:0]        push_word;

   // queue to back
   logic                 pop, q_empty, q_full;
   mvfb_tag_type         head_tag;
   logic [QW-1:0]        head_word;

   mvfb_rsp_type         back_rsp;

   // configuration writes are always taken
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_CFG_W'(256);
         height_ff <= DIM_CFG_W'(256);
         settle_ff <= 1'b1;
      end else begin
         // hold off words for one cycle so the frame area catches up
         settle_ff <= csr_write;
         if (csr_write) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  width_ff  <= csr_wdata;
               CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // zero acts as one, anything above the maximum acts as the maximum
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HW'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(height_ff);
      end
      area = w_eff * h_eff;
   end

   always_ff @(posedge clock) begin
      total_ff <= TW'(area);
   end

   // front: accept and classify words, advance the load and blur walks
   mvfb_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_source_pixel (req_source_pixel),
      .req_shift_x      (req_shift_x),
      .req_shift_y      (req_shift_y),
      .w_eff            (w_eff),
      .h_eff            (h_eff),
      .total            (total_ff),
      .cfg_settle       (settle_ff),
      .q_full           (q_full),
      .push             (push),
      .push_tag         (push_tag),
      .push_data        (push_data),
      .push_addr        (push_addr),
      .push_x           (push_x),
      .push_y           (push_y)
   );

   assign push_word = {push_data, push_addr, push_x, push_y};

   // queue: decouple the front from the store port
   mvfb_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_tag  (push_tag),
      .push_word (push_word),
      .pop       (pop),
      .head_tag  (head_tag),
      .head_word (head_word),
      .empty     (q_empty),
      .full      (q_full)
   );

   // back: sample the store and sum the quartered pixels
   mvfb_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .w_eff     (w_eff),
      .h_eff     (h_eff),
      .q_empty   (q_empty),
      .q_tag     (head_tag),
      .q_data    (head_word[AW + XW + YW +: PIXEL_W]),
      .q_addr    (head_word[XW + YW +: AW]),
      .q_x       ($signed(head_word[YW +: XW])),
      .q_y       ($signed(head_word[0 +: YW])),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp       (back_rsp)
   );

   assign rsp_blurred_pixel = back_rsp.blurred_pixel;
   assign rsp_last_of_frame = back_rsp.last_of_frame;

endmodule

// File: tb/sv/motion_vector_frame_blur_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// motion_vector_frame_blur_tb
// Self-checking bench for the motion vector frame blur. A scoreboard class
// keeps a shadow frame store, the load and blur walks and the frame size. It
// predicts every blurred pixel from the words the block accepts and checks
// the result stream in order. Stimulus fills each frame before it is blurred,
// then mixes loads and displaced blurs over many frame sizes, with the
// register extremes among them.
// ============================================================================
module motion_vector_frame_blur_tb;
   import mvfb_pkg::*;

   localparam int MAX_W         = 256;
   localparam int MAX_H         = 256;
   localparam int STORE_DEPTH   = MAX_W * MAX_H;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_WORDS  = 1300;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int MAX_PRINTS    = 100;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow frame store, walk state and expected pixel queue
   // -------------------------------------------------------------------------
   class blur_scoreboard;
      bit [PIXEL_W-1:0] frame_pix   [STORE_DEPTH];
      bit               frame_valid [STORE_DEPTH];
      int unsigned      width_reg  = 256;
      int unsigned      height_reg = 256;
      int unsigned      load_pos;
      int unsigned      walk_col;
      int unsigned      walk_row;
      mvfb_rsp_type     pixel_q [$];
      int unsigned      mismatches;

      // effective dimensions: zero acts as one, oversize acts as the maximum
      function int unsigned cols();
         return (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
      endfunction

      function int unsigned rows();
         return (height_reg == 0) ? 1 : ((height_reg > MAX_H) ? MAX_H : height_reg);
      endfunction

      function int unsigned pending();
         return pixel_q.size();
      endfunction

      function void set_dim(logic [CSR_IDX_W-1:0] idx, logic [DIM_CFG_W-1:0] val);
         if (idx == CSR_FRAME_WIDTH)
            width_reg = 32'(val);
         else if (idx == CSR_FRAME_HEIGHT)
            height_reg = 32'(val);
      endfunction

      // true once every entry of the current frame holds a loaded pixel
      function bit frame_filled();
         int unsigned total;
         total = cols() * rows();
         for (int unsigned i = 0; i < total; i++) begin
            if (!frame_valid[i])
               return 1'b0;
         end
         return 1'b1;
      endfunction

      // one clamped, byte-quartered sample
      function bit [PIXEL_W-1:0] quarter_tap(int x, int y);
         int cx;
         int cy;
         cx = (x < 0) ? 0 : ((x > int'(cols()) - 1) ? int'(cols()) - 1 : x);
         cy = (y < 0) ? 0 : ((y > int'(rows()) - 1) ? int'(rows()) - 1 : y);
         return (frame_pix[cy * int'(cols()) + cx] >> 2) & QUARTER_MASK;
      endfunction

      function void note_word(logic act, logic [PIXEL_W-1:0] pix,
                              logic signed [SHIFT_W-1:0] sx,
                              logic signed [SHIFT_W-1:0] sy);
         int unsigned  total;
         int           x;
         int           y;
         mvfb_rsp_type want;
         total = cols() * rows();
         if (act == ACT_LOAD) begin
            if (load_pos >= total)
               load_pos = 0;
            frame_pix[load_pos]   = pix;
            frame_valid[load_pos] = 1'b1;
            load_pos++;
            if (load_pos >= total)
               load_pos = 0;
            return;
         end
         // restart the walk if a size change left it outside the frame
         if (walk_col >= cols() || walk_row >= rows()) begin
            walk_col = 0;
            walk_row = 0;
         end
         x = int'(walk_col) + int'(sx);
         y = int'(walk_row) + int'(sy);
         want.blurred_pixel = quarter_tap(x - 2, y + 1) + quarter_tap(x + 2, y + 1)
                            + quarter_tap(x, y - 2) + quarter_tap(x, y);
         want.last_of_frame = (walk_col == cols() - 1) && (walk_row == rows() - 1);
         pixel_q.push_back(want);
         walk_col++;
         if (walk_col >= cols()) begin
            walk_col = 0;
            walk_row++;
            if (walk_row >= rows())
               walk_row = 0;
         end
      endfunction

      function void report_mismatch(string what, logic [PIXEL_W-1:0] got,
                                    logic [PIXEL_W-1:0] want);
         if (mismatches < MAX_PRINTS)
            $display("%0t ns MISMATCH %s: got %h, want %h", $time, what, got, want);
         mismatches++;
      endfunction

      function void check_result(logic [PIXEL_W-1:0] pix, logic last);
         mvfb_rsp_type want;
         if (pixel_q.size() == 0) begin
            report_mismatch("result with nothing pending", pix, '0);
            return;
         end
         want = pixel_q.pop_front();
         if (pix !== want.blurred_pixel)
            report_mismatch("blurred_pixel", pix, want.blurred_pixel);
         if (last !== want.last_of_frame)
            report_mismatch("last_of_frame", PIXEL_W'(last),
                            PIXEL_W'(want.last_of_frame));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, DUT signals and instance
   // -------------------------------------------------------------------------
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic                        req_action = ACT_LOAD;
   logic [PIXEL_W-1:0]          req_source_pixel = '0;
   logic signed [SHIFT_W-1:0]   req_shift_x = '0;
   logic signed [SHIFT_W-1:0]   req_shift_y = '0;
   logic                        rsp_valid;
   logic [PIXEL_W-1:0]          rsp_blurred_pixel;
   logic                        rsp_last_of_frame;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = CSR_FRAME_WIDTH;
   logic [DIM_CFG_W-1:0]        csr_wdata = '0;

   blur_scoreboard sb = new();
   int unsigned    burst_left;
   int unsigned    sent_count;

   always #10 clock = ~clock;

   motion_vector_frame_blur #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_source_pixel  (req_source_pixel),
      .req_shift_x       (req_shift_x),
      .req_shift_y       (req_shift_y),
      .rsp_valid         (rsp_valid),
      .rsp_blurred_pixel (rsp_blurred_pixel),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Results cannot be held off: take every strobed word at the edge that
   // ends its cycle. Outputs are read before this edge's updates land.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_blurred_pixel, rsp_last_of_frame);
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // Send one input word. The sender works in bursts; between bursts drop
   // start for a random gap. Hold start and the fields until busy is low at
   // an edge, which is the edge that takes the word.
   task automatic send_word(input logic act, input logic [PIXEL_W-1:0] pix,
                            input logic signed [SHIFT_W-1:0] sx,
                            input logic signed [SHIFT_W-1:0] sy);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      start            <= 1'b1;
      req_action       <= act;
      req_source_pixel <= pix;
      req_shift_x      <= sx;
      req_shift_y      <= sy;
      do @(posedge clock); while (busy);
      sb.note_word(act, pix, sx, sy);
      sent_count++;
   endtask

   // Drop start and hold until every pending pixel is back, then let the
   // last loads retire; loads give no result to wait on.
   task automatic wait_drained();
      start <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one dimension register; valid drops for a cycle after each write.
   task automatic write_dim(input logic [CSR_IDX_W-1:0] idx,
                            input logic [DIM_CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_dim(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Load random pixels until no blur can touch an entry never written.
   task automatic fill_frame();
      while (!sb.frame_filled())
         send_word(ACT_LOAD, $urandom(), SHIFT_W'($urandom()), SHIFT_W'($urandom()));
   endtask

   // Random mix of loads and blurs for one frame size. Shifts stay mostly
   // near the frame so clamping and in-frame taps both show up; some span
   // the whole signed range.
   task automatic run_phase(input int unsigned n_words);
      int unsigned               pause_at;
      int                        span;
      logic signed [SHIFT_W-1:0] sx;
      logic signed [SHIFT_W-1:0] sy;
      pause_at = $urandom_range(0, n_words - 1);
      span = (sb.cols() > sb.rows()) ? int'(sb.cols()) + 3 : int'(sb.rows()) + 3;
      if (span > 127)
         span = 127;
      for (int unsigned i = 0; i < n_words; i++) begin
         if (i == pause_at)
            wait_drained();
         if ($urandom_range(0, 9) < 3) begin
            send_word(ACT_LOAD, $urandom(), SHIFT_W'($urandom()), SHIFT_W'($urandom()));
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               sx = SHIFT_W'($urandom());
               sy = SHIFT_W'($urandom());
            end else begin
               sx = SHIFT_W'(int'($urandom_range(0, 2 * span)) - span);
               sy = SHIFT_W'(int'($urandom_range(0, 2 * span)) - span);
            end
            send_word(ACT_BLUR, $urandom(), sx, sy);
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int unsigned          phase;
      int unsigned          waited;
      logic [DIM_CFG_W-1:0] wv;
      logic [DIM_CFG_W-1:0] hv;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a 2x3 frame with extreme pixels, then blurs at the shift
      // extremes. Twelve blurs wrap the walk and raise the last-pixel flag
      // twice; a seventh load, after the load position wrapped, overwrites
      // the first pixel.
      write_dim(CSR_FRAME_WIDTH, 9'd2);
      write_dim(CSR_FRAME_HEIGHT, 9'd3);
      send_word(ACT_LOAD, 32'h0000_0000, 8'sd0, 8'sd0);
      send_word(ACT_LOAD, 32'hFFFF_FFFF, 8'sd0, 8'sd0);
      send_word(ACT_LOAD, 32'h0303_0303, 8'sd0, 8'sd0);
      send_word(ACT_LOAD, 32'hFCFC_FCFC, 8'sd0, 8'sd0);
      send_word(ACT_LOAD, 32'h1234_5678, 8'sd0, 8'sd0);
      send_word(ACT_LOAD, 32'hA5C3_0F96, 8'sd0, 8'sd0);
      send_word(ACT_BLUR, 32'hFFFF_FFFF, 8'sd0, 8'sd0);
      send_word(ACT_BLUR, 32'h0000_0000, -8'sd128, -8'sd128);
      send_word(ACT_BLUR, 32'h0000_0000, 8'sd127, 8'sd127);
      send_word(ACT_BLUR, 32'h0000_0000, -8'sd128, 8'sd127);
      send_word(ACT_BLUR, 32'h0000_0000, 8'sd127, -8'sd128);
      send_word(ACT_BLUR, 32'h0000_0000, 8'sd1, -8'sd1);
      send_word(ACT_BLUR, 32'h0000_0000, -8'sd1, 8'sd2);
      send_word(ACT_BLUR, 32'h0000_0000, -8'sd2, -8'sd1);
      send_word(ACT_BLUR, 32'h0000_0000, 8'sd0, 8'sd3);
      send_word(ACT_BLUR, 32'h0000_0000, 8'sd2, 8'sd0);
      send_word(ACT_BLUR, 32'h0000_0000, 8'sd0, -8'sd2);
      send_word(ACT_LOAD, 32'h5A5A_5A5A, 8'sd0, 8'sd0);
      send_word(ACT_BLUR, 32'h0000_0000, 8'sd1, 8'sd1);

      // Random phases over many frame sizes; the first few hit the register
      // extremes: oversize, exact maximum and zero.
      phase = 0;
      while (sent_count < RANDOM_WORDS) begin
         wait_drained();
         case (phase)
            0: begin wv = 9'd511; hv = 9'd1;   end
            1: begin wv = 9'd1;   hv = 9'd256; end
            2: begin wv = 9'd0;   hv = 9'd0;   end
            3: begin wv = 9'd256; hv = 9'd511; end
            default: begin
               wv = ($urandom_range(0, 7) == 0) ? 9'd0 : 9'($urandom_range(1, 12));
               hv = ($urandom_range(0, 7) == 0) ? 9'd0 : 9'($urandom_range(1, 12));
            end
         endcase
         // phase 3 keeps height 511 only briefly: follow with height 1
         if (phase == 3) begin
            write_dim(CSR_FRAME_HEIGHT, hv);
            write_dim(CSR_FRAME_WIDTH, wv);
            write_dim(CSR_FRAME_HEIGHT, 9'd1);
         end else if (phase >= 4 && $urandom_range(0, 3) == 0) begin
            // resize one dimension only; the walks may restart
            if ($urandom_range(0, 1) == 0)
               write_dim(CSR_FRAME_WIDTH, wv);
            else
               write_dim(CSR_FRAME_HEIGHT, hv);
         end else if ($urandom_range(0, 1) == 0) begin
            write_dim(CSR_FRAME_WIDTH, wv);
            write_dim(CSR_FRAME_HEIGHT, hv);
         end else begin
            write_dim(CSR_FRAME_HEIGHT, hv);
            write_dim(CSR_FRAME_WIDTH, wv);
         end
         fill_frame();
         run_phase(phase < 4 ? 60 : $urandom_range(40, 120));
         phase++;
      end

      // Drain with a bound, then settle for the blur latency.
      start <= 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch("pixels never returned", sb.pending(), '0);

      if (sb.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of a few thousand words.
   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
